>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ANY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/i2cmbc_pkg.sv
// Shared types and constants of the I2C master byte controller.
package i2cmbc_pkg;

    localparam int WAIT_WIDTH = 12;
    localparam int CFG_WIDTH  = 12;
    localparam int QUARTER_RESET = 33;

    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_RECV  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;
    localparam logic [2:0] CMD_WRITE = 3'd6;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BUS_LOW   = 3'd1;
    localparam logic [2:0] STATUS_DEV_NACK  = 3'd2;
    localparam logic [2:0] STATUS_REG_NACK  = 3'd3;
    localparam logic [2:0] STATUS_DATA_NACK = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] device_addr;
        logic [7:0] register_addr;
        logic [7:0] data_byte;
        logic       ack_level;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic [2:0]            active;
        logic [2:0]            prim;
        logic [2:0]            step;
        logic [3:0]            bit_idx;
        logic [WAIT_WIDTH-1:0] wait_cnt;
        logic [7:0]            shift;
        logic [1:0]            byte_num;
        logic                  scl;
        logic                  sda;
        logic [7:0]            received;
        logic                  last_ack;
        logic [2:0]            result;
        logic [7:0]            reg_latch;
        logic [7:0]            data_latch;
    } t_state;

endpackage

>>> hdl/i2c_master_byte_controller_core.sv
// I2C master byte controller: one tick per input transfer, one result per tick.
// A tick's result is registered and shown in the next cycle. Throughput: one tick
// per clock; the output register takes a new tick only while it is empty or its
// result is taken, and pins hold for quarter_ticks + 1 ticks per level.
// Reset: synchronous, active low; lines released high, sequencer idle, hold = 33.
module i2c_master_byte_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,       // quarter_ticks
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // device_addr[7:0], register_addr[15:8], data_byte[23:16], ack_level[24],
    // sda_in[25], zero fill
    input  logic [31:0] i_s_axis_tdata,
    input  logic [2:0]  i_s_axis_tuser,    // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // scl[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4], ack_seen[12],
    // status[15:13]
    output logic [15:0] o_m_axis_tdata
);

    localparam int WW = i2cmbc_pkg::WAIT_WIDTH;
    localparam int CW = i2cmbc_pkg::CFG_WIDTH;

    i2cmbc_pkg::t_state r_state;
    i2cmbc_pkg::t_state n_state;
    i2cmbc_pkg::t_state rst_state;
    i2cmbc_pkg::t_cmd   cmd;
    logic [WW-1:0]      r_quarter;
    logic [CW+WW-1:0]   cfg_ext;
    logic               step_done;
    logic               in_xfer;
    logic               r_out_valid;
    logic [15:0]        r_out_data;

    assign cmd.op            = i_s_axis_tuser;
    assign cmd.device_addr   = i_s_axis_tdata[7:0];
    assign cmd.register_addr = i_s_axis_tdata[15:8];
    assign cmd.data_byte     = i_s_axis_tdata[23:16];
    assign cmd.ack_level     = i_s_axis_tdata[24];
    assign cmd.sda_in        = i_s_axis_tdata[25];

    assign cfg_ext = {{WW{1'b0}}, i_cfg_wdata};

    // idle sequencer with both lines released
    always_comb begin
        rst_state     = '0;
        rst_state.scl = 1'b1;
        rst_state.sda = 1'b1;
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    i2cmbc_step u_step (
        .i_state   (r_state),
        .i_cmd     (cmd),
        .i_quarter (r_quarter),
        .o_state   (n_state),
        .o_done    (step_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter <= WW'(i2cmbc_pkg::QUARTER_RESET);
        end else if (i_cfg_we) begin
            r_quarter <= cfg_ext[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_state;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= {n_state.result, n_state.last_ack, n_state.received, step_done,
                           (n_state.active != i2cmbc_pkg::CMD_IDLE), n_state.sda,
                           n_state.scl};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> hdl/i2cmbc_step.sv
// Next-state logic of the bus sequencer for one tick.
module i2cmbc_step (
    input  i2cmbc_pkg::t_state                     i_state,
    input  i2cmbc_pkg::t_cmd                       i_cmd,
    input  logic [i2cmbc_pkg::WAIT_WIDTH-1:0]      i_quarter,
    output i2cmbc_pkg::t_state                     o_state,
    output logic                                   o_done
);

    localparam int WW = i2cmbc_pkg::WAIT_WIDTH;

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;
    localparam logic [2:0] STEP_4 = 3'd4;
    localparam logic [2:0] STEP_5 = 3'd5;
    localparam logic [2:0] STEP_6 = 3'd6;
    localparam logic [2:0] STEP_7 = 3'd7;

    i2cmbc_pkg::t_state n_st;
    logic               fin;
    logic               start_cmd;
    logic [3:0]         bit_inc;
    logic [1:0]         byte_inc;

    assign start_cmd = (i_state.active == i2cmbc_pkg::CMD_IDLE) &&
                       (i_cmd.op >= i2cmbc_pkg::CMD_START) &&
                       (i_cmd.op <= i2cmbc_pkg::CMD_WRITE);
    assign bit_inc  = i_state.bit_idx + 4'd1;
    assign byte_inc = i_state.byte_num + 2'd1;

    always_comb begin
        n_st   = i_state;
        fin    = 1'b0;
        o_done = 1'b0;
        if (start_cmd) begin
            n_st.wait_cnt = '0;
            if (i_cmd.op == i2cmbc_pkg::CMD_WRITE && !i_cmd.sda_in) begin
                // bus held low: report and leave the pins alone
                n_st.result = i2cmbc_pkg::STATUS_BUS_LOW;
                o_done      = 1'b1;
            end else begin
                // first step of the command runs on its arrival tick
                n_st.active   = i_cmd.op;
                n_st.prim     = i_cmd.op;
                n_st.byte_num = 2'd0;
                n_st.bit_idx  = 4'd0;
                n_st.step     = STEP_1;
                n_st.wait_cnt = i_quarter;
                case (i_cmd.op)
                    i2cmbc_pkg::CMD_WRITE: begin
                        n_st.prim       = i2cmbc_pkg::CMD_START;
                        n_st.shift      = i_cmd.device_addr;
                        n_st.reg_latch  = i_cmd.register_addr;
                        n_st.data_latch = i_cmd.data_byte;
                        n_st.scl        = 1'b1;
                        n_st.sda        = 1'b1;
                    end
                    i2cmbc_pkg::CMD_START: begin
                        n_st.scl = 1'b1;
                        n_st.sda = 1'b1;
                    end
                    i2cmbc_pkg::CMD_STOP: n_st.sda = 1'b0;
                    i2cmbc_pkg::CMD_SEND: n_st.shift = i_cmd.data_byte;
                    i2cmbc_pkg::CMD_RECV: n_st.shift = 8'd0;
                    i2cmbc_pkg::CMD_ACK: begin
                        n_st.shift = {7'd0, i_cmd.ack_level};
                        n_st.sda   = i_cmd.ack_level;
                    end
                    default: ;
                endcase
            end
        end else if (i_state.active != i2cmbc_pkg::CMD_IDLE &&
                     i_state.wait_cnt != '0) begin
            n_st.wait_cnt = i_state.wait_cnt - WW'(1);
        end else if (i_state.active != i2cmbc_pkg::CMD_IDLE) begin
            n_st.wait_cnt = i_quarter;
            case (i_state.prim)
                i2cmbc_pkg::CMD_START: begin
                    if (i_state.step == STEP_0) begin
                        n_st.sda  = 1'b1;
                        n_st.scl  = 1'b1;
                        n_st.step = STEP_1;
                    end else if (i_state.step == STEP_1) begin
                        n_st.sda  = 1'b0;
                        n_st.step = STEP_2;
                    end else begin
                        n_st.scl = 1'b0;
                        if (i_state.active == i2cmbc_pkg::CMD_WRITE) begin
                            // device byte follows, its idle first step folded in
                            n_st.prim    = i2cmbc_pkg::CMD_SEND;
                            n_st.bit_idx = 4'd0;
                            n_st.step    = STEP_1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
                i2cmbc_pkg::CMD_STOP: begin
                    case (i_state.step)
                        STEP_0: begin n_st.sda = 1'b0; n_st.step = STEP_1; end
                        STEP_1: begin n_st.scl = 1'b1; n_st.step = STEP_2; end
                        STEP_2: begin n_st.sda = 1'b1; n_st.step = STEP_3; end
                        default: begin
                            if (i_state.active == i2cmbc_pkg::CMD_WRITE) begin
                                n_st.result = i_state.last_ack ?
                                    3'(i2cmbc_pkg::STATUS_DEV_NACK + {1'b0, i_state.byte_num}) :
                                    i2cmbc_pkg::STATUS_OK;
                            end
                            fin = 1'b1;
                        end
                    endcase
                end
                i2cmbc_pkg::CMD_ACK: begin
                    case (i_state.step)
                        STEP_0: begin n_st.sda = i_state.shift[0]; n_st.step = STEP_1; end
                        STEP_1: begin n_st.scl = 1'b1; n_st.step = STEP_2; end
                        STEP_2: begin n_st.scl = 1'b0; n_st.step = STEP_3; end
                        STEP_3: begin n_st.sda = 1'b1; n_st.step = STEP_4; end
                        default: fin = 1'b1;
                    endcase
                end
                i2cmbc_pkg::CMD_SEND: begin
                    case (i_state.step)
                        STEP_0: n_st.step = STEP_1;
                        STEP_1: begin
                            n_st.sda   = i_state.shift[7];
                            n_st.shift = {i_state.shift[6:0], 1'b0};
                            n_st.step  = STEP_2;
                        end
                        STEP_2: begin n_st.scl = 1'b1; n_st.step = STEP_3; end
                        STEP_3: begin
                            n_st.scl     = 1'b0;
                            n_st.bit_idx = bit_inc;
                            n_st.step    = (bit_inc < 4'd8) ? STEP_1 : STEP_4;
                        end
                        STEP_4: begin n_st.sda = 1'b1; n_st.step = STEP_5; end
                        STEP_5: begin n_st.scl = 1'b1; n_st.step = STEP_6; end
                        STEP_6: begin
                            n_st.last_ack = i_cmd.sda_in;
                            n_st.scl      = 1'b0;
                            n_st.step     = STEP_7;
                        end
                        default: begin
                            if (i_state.active == i2cmbc_pkg::CMD_WRITE) begin
                                n_st.bit_idx = 4'd0;
                                n_st.step    = STEP_1;
                                if (i_state.last_ack || i_state.byte_num >= 2'd2) begin
                                    // stop with its first pin change folded in
                                    n_st.prim = i2cmbc_pkg::CMD_STOP;
                                    n_st.sda  = 1'b0;
                                end else begin
                                    n_st.byte_num = byte_inc;
                                    n_st.shift    = (byte_inc == 2'd1) ?
                                                    i_state.reg_latch : i_state.data_latch;
                                    n_st.prim     = i2cmbc_pkg::CMD_SEND;
                                end
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                end
                i2cmbc_pkg::CMD_RECV: begin
                    case (i_state.step)
                        STEP_0: n_st.step = STEP_1;
                        STEP_1: begin n_st.scl = 1'b1; n_st.step = STEP_2; end
                        STEP_2: begin
                            n_st.shift   = {i_state.shift[6:0], i_cmd.sda_in};
                            n_st.scl     = 1'b0;
                            n_st.bit_idx = bit_inc;
                            n_st.step    = (bit_inc < 4'd8) ? STEP_1 : STEP_3;
                        end
                        default: begin
                            n_st.received = i_state.shift;
                            fin           = 1'b1;
                        end
                    endcase
                end
                default: fin = 1'b1;
            endcase
            if (fin) begin
                n_st.active   = i2cmbc_pkg::CMD_IDLE;
                n_st.prim     = i2cmbc_pkg::CMD_IDLE;
                n_st.step     = STEP_0;
                n_st.bit_idx  = 4'd0;
                n_st.wait_cnt = '0;
                o_done        = 1'b1;
            end
        end
    end

    assign o_state = n_st;

endmodule

>>> hdl/i2cmbc_checker.sv
// Port-level checker for the I2C master byte controller, bound to the top level.
`include "assert_macros.svh"

module i2cmbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // every accepted tick shows a result on the next cycle
    `ASSERT_NEXT(a_in_to_out, i_s_axis_tvalid && o_s_axis_tready, o_m_axis_tvalid)
    // an empty output register never blocks the input
    `ASSERT_IMPL(a_ready_empty, !o_m_axis_tvalid, o_s_axis_tready)
    // a completing tick leaves the block idle
    `ASSERT_IMPL(a_done_idle, o_m_axis_tvalid && o_m_axis_tdata[3], !o_m_axis_tdata[2])
    // reset empties the output register
    `ASSERT_NEXT_ANY(a_reset_empty, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind i2c_master_byte_controller_core i2cmbc_checker u_i2cmbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
